[hdl/alrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package alrc_pkg;

   // sizes of the log and the id table
   localparam int LOG_DEPTH = 4096;
   localparam int ID_SPACE  = 65536;

   // field widths fixed by the word format
   localparam int ID_W    = 16;
   localparam int RANGE_W = 12;
   localparam int NUM_W   = 13;
   localparam int KIND_W  = 2;

   // widths derived from the sizes
   localparam int LOG_IDX_W = $clog2(LOG_DEPTH);
   localparam int ID_IDX_W  = $clog2(ID_SPACE);
   localparam int COUNT_W   = $clog2(LOG_DEPTH + 1);

   // request operation
   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // result kind codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // classified request word from the front end
   typedef struct packed {
      op_type               op;
      logic [ID_W-1:0]      visitor_id;
      logic [RANGE_W-1:0]   range_start;
      logic [RANGE_W-1:0]   range_end;
      logic                 id_bad;
      logic                 span_bad;
   } req_item_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } req_head_type;

   // result word
   typedef struct packed {
      kind_type         kind;
      logic [NUM_W-1:0] visit_number;
      logic [NUM_W-1:0] distinct_count;
      logic [NUM_W-1:0] span_length;
   } rsp_item_type;

endpackage

`default_nettype wire

[hdl/access_log_distinct_range_count.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   handshake            word
// request   push / full          req_command, req_visitor_id, req_range_start, req_range_end
// response  empty / pop          rsp_result_kind, rsp_visit_number, rsp_distinct_count,
//                                rsp_span_length
//
// an add goes through the id table read, the update and the hand-off in the back end
// a query makes one previous-occurrence read per log entry in the span
// errors go straight to the hand-off; up to 2 requests and 2 responses wait in the queues
// after reset the id table is zeroed entry by entry with full held high
// a full response queue stalls the back end; the request queue keeps filling

module access_log_distinct_range_count import alrc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_command,
   input  wire logic [ID_W-1:0]    req_visitor_id,
   input  wire logic [RANGE_W-1:0] req_range_start,
   input  wire logic [RANGE_W-1:0] req_range_end,
   output logic                    empty,
   input  wire logic               pop,
   output logic [KIND_W-1:0]       rsp_result_kind,
   output logic [NUM_W-1:0]        rsp_visit_number,
   output logic [NUM_W-1:0]        rsp_distinct_count,
   output logic [NUM_W-1:0]        rsp_span_length
);

   req_head_type head;
   logic         head_pop;
   logic         busy;
   rsp_item_type back_item;
   logic         back_push;
   logic         back_full;
   rsp_item_type out_item;

   // accept and classify
   alrc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_command     (req_command),
      .req_visitor_id  (req_visitor_id),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .busy            (busy),
      .head            (head),
      .head_pop        (head_pop)
   );

   // execute against the log
   alrc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .busy     (busy),
      .rsp_item (back_item),
      .rsp_push (back_push),
      .rsp_full (back_full)
   );

   // response queue
   alrc_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .in_item  (back_item),
      .in_push  (back_push),
      .in_full  (back_full),
      .out_item (out_item),
      .empty    (empty),
      .pop      (pop)
   );

   assign rsp_result_kind    = out_item.kind;
   assign rsp_visit_number   = out_item.visit_number;
   assign rsp_distinct_count = out_item.distinct_count;
   assign rsp_span_length    = out_item.span_length;

endmodule

`default_nettype wire

[hdl/alrc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module alrc_front import alrc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_command,
   input  wire logic [ID_W-1:0]    req_visitor_id,
   input  wire logic [RANGE_W-1:0] req_range_start,
   input  wire logic [RANGE_W-1:0] req_range_end,
   input  wire logic               busy,
   output req_head_type            head,
   input  wire logic               head_pop
);

   localparam int QDEPTH = 2;

   req_item_type       q_ff [QDEPTH];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         cnt_ff;
   logic [1:0]         cnt_in;
   logic               do_push;
   logic               do_pop;
   req_item_type       item;

   // classify the incoming word
   always_comb begin
      item.op          = req_command ? OP_QUERY : OP_ADD;
      item.visitor_id  = req_visitor_id;
      item.range_start = req_range_start;
      item.range_end   = req_range_end;
      item.id_bad      = 32'(req_visitor_id) >= ID_SPACE;
      item.span_bad    = req_range_start > req_range_end;
   end

   // queue control
   assign full    = (cnt_ff == 2'(QDEPTH)) | busy;
   assign do_push = push & ~full;
   assign do_pop  = head_pop & (cnt_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = cnt_ff != 2'd0;
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hdl/alrc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module alrc_back import alrc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_head_type head,
   output logic              head_pop,
   output logic              busy,
   output rsp_item_type      rsp_item,
   output logic              rsp_push,
   input  wire logic         rsp_full
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_Q_RUN,
      ST_Q_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] visits;
      logic [COUNT_W-1:0] last;
   } id_entry_type;

   // per-id table and per-position previous occurrence
   id_entry_type       id_mem   [ID_SPACE];
   logic [COUNT_W-1:0] prev_mem [LOG_DEPTH];

   state_type          state_ff;
   state_type          state_in;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [COUNT_W-1:0] entry_count_in;
   logic [ID_IDX_W-1:0] clr_addr_ff;
   logic [ID_IDX_W-1:0] clr_addr_in;
   logic [ID_IDX_W-1:0] id_ff;
   logic [ID_IDX_W-1:0] id_in;
   logic [LOG_IDX_W-1:0] s_ff;
   logic [LOG_IDX_W-1:0] s_in;
   logic [LOG_IDX_W-1:0] e_ff;
   logic [LOG_IDX_W-1:0] e_in;
   logic [LOG_IDX_W-1:0] p_ff;
   logic [LOG_IDX_W-1:0] p_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rd_valid_ff;
   logic               rd_valid_in;
   rsp_item_type       result_ff;
   rsp_item_type       result_in;

   id_entry_type       id_rdata_ff;
   logic [COUNT_W-1:0] prev_rdata_ff;

   logic               id_we;
   logic [ID_IDX_W-1:0] id_waddr;
   id_entry_type       id_wdata;
   logic               prev_we;
   logic [LOG_IDX_W-1:0] prev_waddr;
   logic [COUNT_W-1:0] prev_wdata;
   logic [ID_IDX_W-1:0] id_raddr;
   logic               hit;
   logic               log_full;
   logic [COUNT_W-1:0] visits_new;
   rsp_item_type       err_item;

   assign id_raddr   = ID_IDX_W'(head.item.visitor_id);
   assign hit        = rd_valid_ff && (prev_rdata_ff <= COUNT_W'(s_ff));
   assign log_full   = 32'(entry_count_ff) >= LOG_DEPTH;
   assign visits_new = id_rdata_ff.visits + COUNT_W'(1);

   always_comb begin
      err_item                = '0;
      err_item.kind           = KIND_ERROR;
   end

   // next state and memory write control
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      clr_addr_in    = clr_addr_ff;
      id_in          = id_ff;
      s_in           = s_ff;
      e_in           = e_ff;
      p_in           = p_ff;
      count_in       = count_ff;
      rd_valid_in    = 1'b0;
      result_in      = result_ff;
      head_pop       = 1'b0;
      rsp_push       = 1'b0;
      id_we          = 1'b0;
      id_waddr       = id_ff;
      id_wdata       = '0;
      prev_we        = 1'b0;
      prev_waddr     = LOG_IDX_W'(entry_count_ff);
      prev_wdata     = id_rdata_ff.last;

      case (state_ff)
         // zero the id table one entry per cycle after reset
         ST_CLEAR: begin
            id_we       = 1'b1;
            id_waddr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ID_IDX_W'(1);
            if (clr_addr_ff == ID_IDX_W'(ID_SPACE - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take the next word and check it against the log state
         ST_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               if (head.item.op == OP_ADD) begin
                  if (log_full || head.item.id_bad) begin
                     result_in = err_item;
                     state_in  = ST_DONE;
                  end else begin
                     id_in    = id_raddr;
                     state_in = ST_ADD_RD;
                  end
               end else begin
                  if (head.item.span_bad ||
                      (32'(head.item.range_end) >= 32'(entry_count_ff))) begin
                     result_in = err_item;
                     state_in  = ST_DONE;
                  end else begin
                     s_in     = LOG_IDX_W'(head.item.range_start);
                     e_in     = LOG_IDX_W'(head.item.range_end);
                     p_in     = LOG_IDX_W'(head.item.range_start);
                     count_in = '0;
                     state_in = ST_Q_RUN;
                  end
               end
            end
         end

         // id entry is in hand: append and update
         ST_ADD_RD: begin
            id_we                    = 1'b1;
            id_wdata.visits          = visits_new;
            id_wdata.last            = entry_count_ff + COUNT_W'(1);
            prev_we                  = 1'b1;
            entry_count_in           = entry_count_ff + COUNT_W'(1);
            result_in                = '0;
            result_in.kind           = KIND_ADD;
            result_in.visit_number   = NUM_W'(visits_new);
            state_in                 = ST_DONE;
         end

         // stream the span through the read port, count first appearances
         ST_Q_RUN: begin
            rd_valid_in = 1'b1;
            p_in        = p_ff + LOG_IDX_W'(1);
            if (hit) begin
               count_in = count_ff + COUNT_W'(1);
            end
            if (p_ff == e_ff) begin
               state_in = ST_Q_DRAIN;
            end
         end

         // last read comes back
         ST_Q_DRAIN: begin
            result_in                = '0;
            result_in.kind           = KIND_QUERY;
            result_in.distinct_count = NUM_W'(count_ff + COUNT_W'(hit));
            result_in.span_length    = NUM_W'(32'(e_ff) - 32'(s_ff) + 32'd1);
            state_in                 = ST_DONE;
         end

         // hand the result to the output queue
         ST_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         entry_count_ff <= '0;
         clr_addr_ff    <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         clr_addr_ff    <= clr_addr_in;
         rd_valid_ff    <= rd_valid_in;
      end
      id_ff     <= id_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      p_ff      <= p_in;
      count_ff  <= count_in;
      result_ff <= result_in;
   end

   // id table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_waddr] <= id_wdata;
      end
      id_rdata_ff <= id_mem[id_raddr];
   end

   // previous occurrence table
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rdata_ff <= prev_mem[p_ff];
   end

   assign busy     = state_ff == ST_CLEAR;
   assign rsp_item = result_ff;

endmodule

`default_nettype wire

[hdl/alrc_rsp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module alrc_rsp_queue import alrc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire rsp_item_type in_item,
   input  wire logic   in_push,
   output logic        in_full,
   output rsp_item_type out_item,
   output logic        empty,
   input  wire logic   pop
);

   localparam int QDEPTH = 2;

   rsp_item_type q_ff [QDEPTH];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   cnt_ff;
   logic [1:0]   cnt_in;
   logic         do_push;
   logic         do_pop;

   assign in_full = cnt_ff == 2'(QDEPTH);
   assign empty   = cnt_ff == 2'd0;
   assign do_push = in_push & ~in_full;
   assign do_pop  = pop & ~empty;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end

   assign out_item = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[tb/sv/access_log_distinct_range_count_tb.sv]
`timescale 1ns / 1ps

module access_log_distinct_range_count_tb;
   import alrc_pkg::*;

   localparam int IDLE_PCT     = 31;
   localparam int RANDOM_WORDS = 140;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 1_500_000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               pop = 1'b0;
   logic               req_command = 1'b0;
   logic [ID_W-1:0]    req_visitor_id = '0;
   logic [RANGE_W-1:0] req_range_start = '0;
   logic [RANGE_W-1:0] req_range_end = '0;
   logic               full;
   logic               empty;
   logic [KIND_W-1:0]  rsp_result_kind;
   logic [NUM_W-1:0]   rsp_visit_number;
   logic [NUM_W-1:0]   rsp_distinct_count;
   logic [NUM_W-1:0]   rsp_span_length;

   // shadow copy of the log, the per-id tables and the visit counts
   bit [NUM_W-1:0] visits_by_id [ID_SPACE];
   bit [NUM_W-1:0] last_pos_by_id [ID_SPACE];
   bit [NUM_W-1:0] prev_pos_by_entry [LOG_DEPTH];
   int             log_len = 0;

   rsp_item_type awaited_rsps [$];

   int  req_idle_pct = IDLE_PCT;
   int  rsp_idle_pct = IDLE_PCT;
   bit  stall_go = 1'b0;
   bit  rsp_hold = 1'b0;
   int  err_count = 0;
   int  cycle_count = 0;
   int  seen_adds = 0;
   int  seen_queries = 0;
   int  seen_rejects = 0;

   access_log_distinct_range_count dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_command        (req_command),
      .req_visitor_id     (req_visitor_id),
      .req_range_start    (req_range_start),
      .req_range_end      (req_range_end),
      .empty              (empty),
      .pop                (pop),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_visit_number   (rsp_visit_number),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_span_length    (rsp_span_length)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t timeout with %0d words still awaited", $time, awaited_rsps.size());
         $display("access_log_distinct_range_count_tb: done, errors");
         $finish;
      end
   end

   // append to the log or count distinct ids over a span, updating the shadow state
   function automatic rsp_item_type log_and_count(op_type op, logic [ID_W-1:0] id,
                                                  logic [RANGE_W-1:0] span_lo,
                                                  logic [RANGE_W-1:0] span_hi);
      rsp_item_type r;
      int unsigned  hits;
      r = '0;
      r.kind = KIND_ERROR;
      if (op == OP_ADD) begin
         if (log_len < LOG_DEPTH) begin
            prev_pos_by_entry[log_len] = last_pos_by_id[id];
            last_pos_by_id[id] = NUM_W'(log_len + 1);
            visits_by_id[id] = visits_by_id[id] + 1'b1;
            log_len++;
            r.kind = KIND_ADD;
            r.visit_number = visits_by_id[id];
         end
      end else if (span_lo <= span_hi && span_hi < log_len) begin
         hits = 0;
         // an entry is a first appearance when its previous occurrence precedes the span
         for (int p = span_lo; p <= span_hi; p++)
            if (prev_pos_by_entry[p] <= span_lo) hits++;
         r.kind = KIND_QUERY;
         r.distinct_count = NUM_W'(hits);
         r.span_length = NUM_W'(span_hi - span_lo + 1);
      end
      return r;
   endfunction

   task automatic set_idle(int pct);
      req_idle_pct = pct;
      rsp_idle_pct <= pct;
   endtask

   // offer one word and wait until it is taken
   task automatic offer_word(op_type op, logic [ID_W-1:0] id,
                             logic [RANGE_W-1:0] span_lo, logic [RANGE_W-1:0] span_hi);
      while ($urandom_range(99) < req_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_command <= op;
      req_visitor_id <= id;
      req_range_start <= span_lo;
      req_range_end <= span_hi;
      @(posedge clock);
      while (full) @(posedge clock);
      awaited_rsps.push_back(log_and_count(op, id, span_lo, span_hi));
   endtask

   // unused fields carry random bits
   task automatic log_visit(logic [ID_W-1:0] id);
      offer_word(OP_ADD, id, RANGE_W'($urandom), RANGE_W'($urandom));
   endtask

   task automatic ask_span(logic [RANGE_W-1:0] span_lo, logic [RANGE_W-1:0] span_hi);
      offer_word(OP_QUERY, ID_W'($urandom), span_lo, span_hi);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
         err_count++;
      end
   endtask

   // result side: check each taken word, then pick the next pop
   always @(posedge clock) begin : rsp_checker
      rsp_item_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (awaited_rsps.size() == 0) begin
               $display("%0t unexpected word: expected none, actual %0d %0d %0d %0d",
                        $time, rsp_result_kind, rsp_visit_number, rsp_distinct_count,
                        rsp_span_length);
               err_count++;
            end else begin
               want = awaited_rsps.pop_front();
               check_field("result_kind", want.kind, rsp_result_kind);
               check_field("visit_number", want.visit_number, rsp_visit_number);
               check_field("distinct_count", want.distinct_count, rsp_distinct_count);
               check_field("span_length", want.span_length, rsp_span_length);
               case (want.kind)
                  KIND_ADD: seen_adds++;
                  KIND_QUERY: seen_queries++;
                  default: seen_rejects++;
               endcase
            end
         end
         pop <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // long receiver hold-off, counted here
   always begin
      wait (stall_go);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
      stall_go = 1'b0;
   end

   // any query on an empty log is rejected
   task automatic test_empty_log_queries();
      ask_span(0, 0);
      ask_span(RANGE_W'(LOG_DEPTH - 1), 0);
   endtask

   // extreme ids and repeat visits
   task automatic test_first_visits();
      log_visit(16'h0000);
      log_visit(16'hFFFF);
      log_visit(16'h0000);
      log_visit(16'h5555);
      log_visit(16'hAAAA);
      log_visit(16'hFFFF);
   endtask

   // spans at the edges of the log, reversed spans and spans past the end
   task automatic test_span_edges();
      ask_span(0, 0);
      ask_span(0, RANGE_W'(log_len - 1));
      ask_span(2, RANGE_W'(log_len - 1));
      ask_span(RANGE_W'(log_len - 1), RANGE_W'(log_len - 1));
      ask_span(3, 1);
      ask_span(0, RANGE_W'(log_len));
      ask_span(RANGE_W'(LOG_DEPTH - 1), RANGE_W'(LOG_DEPTH - 1));
      ask_span(0, RANGE_W'(LOG_DEPTH - 1));
   endtask

   // mostly well-formed traffic over a small id pool, some noise
   task automatic test_random_mix();
      logic [ID_W-1:0] regulars [12];
      int              pick;
      int              lo;
      int              hi;
      foreach (regulars[i]) regulars[i] = ID_W'($urandom);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - 40) set_idle(0);
         pick = $urandom_range(99);
         if (pick < 38) begin
            log_visit(regulars[$urandom_range(11)]);
         end else if (pick < 70) begin
            lo = $urandom_range(log_len - 1);
            hi = $urandom_range(log_len - 1, lo);
            ask_span(RANGE_W'(lo), RANGE_W'(hi));
         end else if (pick < 85) begin
            log_visit(ID_W'($urandom));
         end else begin
            ask_span(RANGE_W'($urandom), RANGE_W'($urandom));
         end
      end
      set_idle(IDLE_PCT);
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      stall_go = 1'b1;
      req_idle_pct = 0;
      for (int n = 0; n < 12; n++) begin
         if (n % 3 == 2) ask_span(0, RANGE_W'(log_len - 1));
         else log_visit(ID_W'($urandom_range(3)));
      end
      // drop the request while the hold-off runs out
      while (stall_go) begin
         push <= 1'b0;
         @(posedge clock);
      end
      req_idle_pct = IDLE_PCT;
   endtask

   // fill the log, mostly with one id, then reject adds and query spans, the whole log among them
   task automatic test_full_log();
      logic [ID_W-1:0] hot_id;
      int              lo;
      hot_id = ID_W'($urandom);
      set_idle(0);
      while (log_len < LOG_DEPTH)
         log_visit(($urandom_range(3) != 0) ? hot_id : ID_W'($urandom));
      set_idle(IDLE_PCT);
      log_visit(16'h0000);
      log_visit(hot_id);
      ask_span(0, RANGE_W'(LOG_DEPTH - 1));
      ask_span(RANGE_W'(LOG_DEPTH - 1), RANGE_W'(LOG_DEPTH - 1));
      ask_span(0, 0);
      ask_span(RANGE_W'(LOG_DEPTH - 2), RANGE_W'(LOG_DEPTH - 1));
      lo = $urandom_range(LOG_DEPTH - 1);
      ask_span(RANGE_W'(lo), RANGE_W'($urandom_range(LOG_DEPTH - 1, lo)));
      ask_span(RANGE_W'(LOG_DEPTH - 1), 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_log_queries();
      test_first_visits();
      test_span_edges();
      test_random_mix();
      test_backpressure();
      test_full_log();
      push <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d log appends, %0d span queries and %0d rejected words",
               seen_adds, seen_queries, seen_rejects);
      $display("log filled to %0d entries, receiver held off for %0d cycles once",
               log_len, HOLD_CYCLES);
      if (err_count == 0) begin
         $display("access_log_distinct_range_count_tb: done, clean");
      end else begin
         $display("access_log_distinct_range_count_tb: done, errors");
      end
      $finish;
   end

endmodule
